FILE: hdl/mps_pkg.sv
// Shared types, sizes and helpers for the maze path search unit.
// No dependencies; imported by mps_nbr_unit and maze_path_search_dfs_unit.
`default_nettype none

package mps_pkg;

  localparam int SIDE  = 4;
  localparam int CELLS = SIDE * SIDE;
  localparam int RC_W  = (SIDE > 1) ? $clog2(SIDE) : 1;
  localparam int POS_W = $clog2(CELLS);
  localparam int SP_W  = $clog2(CELLS + 1);

  typedef logic [2:0] dir_t;

  // Neighbor order: down, up, right, left, then exhausted
  localparam dir_t DIR_DOWN  = 3'd0;
  localparam dir_t DIR_UP    = 3'd1;
  localparam dir_t DIR_RIGHT = 3'd2;
  localparam dir_t DIR_LEFT  = 3'd3;
  localparam dir_t DIR_DONE  = 3'd4;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_SOLVE = 1'b1;

  typedef struct packed {
    logic [RC_W-1:0] row;
    logic [RC_W-1:0] col;
    dir_t            dir;
  } stk_ent_t;

  // Result of probing one neighbor of the current cell
  typedef struct packed {
    logic             ok;      // inside the grid and open
    logic             goal;    // neighbor is the bottom-right cell
    logic             marked;  // neighbor already on the path
    logic [RC_W-1:0]  row;
    logic [RC_W-1:0]  col;
    logic [POS_W-1:0] pos;
  } nbr_t;

  function automatic logic [POS_W-1:0] cell_pos(input logic [RC_W-1:0] row,
                                                input logic [RC_W-1:0] col);
    return POS_W'(int'(row) * SIDE + int'(col));
  endfunction

endpackage

`default_nettype wire

FILE: hdl/mps_nbr_unit.sv
// Neighbor probe: steps one cell in the given direction and checks bounds,
// maze bit and path mark. Depends on mps_pkg.
`default_nettype none

module mps_nbr_unit
  import mps_pkg::*;
(
  input  logic [RC_W-1:0]  row_i,
  input  logic [RC_W-1:0]  col_i,
  input  dir_t             dir_i,
  input  logic [CELLS-1:0] maze_i,
  input  logic [CELLS-1:0] marks_i,
  output nbr_t             nbr_o
);

  logic            in_grid;
  logic [RC_W-1:0] nrow;
  logic [RC_W-1:0] ncol;
  logic [POS_W-1:0] npos;

  always_comb begin
    in_grid = 1'b0;
    nrow    = row_i;
    ncol    = col_i;
    case (dir_i)
      DIR_DOWN: begin
        in_grid = (int'(row_i) + 1) < SIDE;
        nrow    = row_i + RC_W'(1);
      end
      DIR_UP: begin
        in_grid = (row_i != '0);
        nrow    = row_i - RC_W'(1);
      end
      DIR_RIGHT: begin
        in_grid = (int'(col_i) + 1) < SIDE;
        ncol    = col_i + RC_W'(1);
      end
      DIR_LEFT: begin
        in_grid = (col_i != '0);
        ncol    = col_i - RC_W'(1);
      end
      default: begin
        in_grid = 1'b0;
      end
    endcase
  end

  assign npos = cell_pos(nrow, ncol);

  always_comb begin
    nbr_o.ok     = in_grid && maze_i[npos];
    nbr_o.goal   = (nrow == RC_W'(SIDE - 1)) && (ncol == RC_W'(SIDE - 1));
    nbr_o.marked = marks_i[npos];
    nbr_o.row    = nrow;
    nbr_o.col    = ncol;
    nbr_o.pos    = npos;
  end

endmodule

`default_nettype wire

FILE: hdl/maze_path_search_dfs_unit.sv
// Top level of the maze path search: cell loads, depth-first search sequencer
// and row result output. Depends on mps_pkg and mps_nbr_unit.
`default_nettype none

// A load beat (cmd 0) writes one maze cell in the cycle it is taken and leaves
// busy_o low, so loads can stream one per cycle. A solve beat (cmd 1) raises
// busy_o and runs the search one step per cycle: each cycle either tries one
// neighbor of the cell on top of the search stack through the shared neighbor
// probe, or backs out of an exhausted cell. The solve therefore runs a
// data-dependent number of search steps (up to five per cell visit, none if
// the start cell is closed), then one result beat per grid row in row order
// with row_valid_o high; busy_o drops after the last row. Results cannot be
// held off and must be taken in the cycle they appear. Every maze cell that
// the search may read must have been loaded since reset.
module maze_path_search_dfs_unit
  import mps_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  logic       cmd_i,
  input  logic [1:0] cell_row_i,
  input  logic [1:0] cell_col_i,
  input  logic       cell_open_i,
  output logic       row_valid_o,
  output logic [1:0] row_index_o,
  output logic [3:0] row_path_bits_o,
  output logic       path_found_o,
  output logic       last_row_o
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_EMIT   = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [CELLS-1:0] maze_q;
  logic [CELLS-1:0] marks_q, marks_d;
  stk_ent_t         stk_q [CELLS];
  logic [SP_W-1:0]  sp_q, sp_d;
  logic [RC_W-1:0]  top_row_q, top_row_d;
  logic [RC_W-1:0]  top_col_q, top_col_d;
  dir_t             top_dir_q, top_dir_d;
  logic             found_q, found_d;
  logic [RC_W-1:0]  emit_row_q, emit_row_d;

  logic             accept;
  logic             load_we;
  logic [POS_W-1:0] load_pos;

  logic             stk_we;
  logic [POS_W-1:0] stk_waddr;
  stk_ent_t         stk_wdata;
  logic [SP_W-1:0]  sp_m1;
  logic [SP_W-1:0]  sp_m2;
  stk_ent_t         stk_rdata;
  logic [POS_W-1:0] top_pos;
  nbr_t             nbr;

  assign accept   = start_i && (state_q == ST_IDLE);
  assign load_we  = accept && (cmd_i == CMD_LOAD) &&
                    (int'(cell_row_i) < SIDE) && (int'(cell_col_i) < SIDE);
  assign load_pos = POS_W'(int'(cell_row_i) * SIDE + int'(cell_col_i));

  assign sp_m1     = sp_q - SP_W'(1);
  assign sp_m2     = sp_q - SP_W'(2);
  assign stk_rdata = stk_q[sp_m2[POS_W-1:0]];
  assign top_pos   = cell_pos(top_row_q, top_col_q);

  mps_nbr_unit u_nbr (
    .row_i   (top_row_q),
    .col_i   (top_col_q),
    .dir_i   (top_dir_q),
    .maze_i  (maze_q),
    .marks_i (marks_q),
    .nbr_o   (nbr)
  );

  always_comb begin
    state_d    = state_q;
    marks_d    = marks_q;
    sp_d       = sp_q;
    top_row_d  = top_row_q;
    top_col_d  = top_col_q;
    top_dir_d  = top_dir_q;
    found_d    = found_q;
    emit_row_d = emit_row_q;
    stk_we     = 1'b0;
    stk_waddr  = sp_m1[POS_W-1:0];
    stk_wdata  = '{row: top_row_q, col: top_col_q, dir: top_dir_q + dir_t'(1)};

    case (state_q)
      ST_IDLE: begin
        if (accept && (cmd_i == CMD_SOLVE)) begin
          // Clear marks and enter the start cell if it is open
          marks_d    = '0;
          found_d    = 1'b0;
          emit_row_d = '0;
          top_row_d  = '0;
          top_col_d  = '0;
          top_dir_d  = DIR_DOWN;
          if (maze_q[0]) begin
            marks_d[0] = 1'b1;
            sp_d       = SP_W'(1);
            state_d    = ST_SEARCH;
          end else begin
            sp_d    = '0;
            state_d = ST_EMIT;
          end
        end
      end

      ST_SEARCH: begin
        if (top_dir_q == DIR_DONE) begin
          // Dead end: unmark and pop
          marks_d[top_pos] = 1'b0;
          sp_d             = sp_m1;
          if (sp_q == SP_W'(1)) begin
            state_d = ST_EMIT;
          end else begin
            top_row_d = stk_rdata.row;
            top_col_d = stk_rdata.col;
            top_dir_d = stk_rdata.dir;
          end
        end else begin
          top_dir_d = top_dir_q + dir_t'(1);
          if (nbr.ok && nbr.goal) begin
            marks_d[nbr.pos] = 1'b1;
            found_d          = 1'b1;
            state_d          = ST_EMIT;
          end else if (nbr.ok && !nbr.marked && (int'(sp_q) < CELLS)) begin
            // Push: save the current cell below the new top
            marks_d[nbr.pos] = 1'b1;
            stk_we           = 1'b1;
            sp_d             = sp_q + SP_W'(1);
            top_row_d        = nbr.row;
            top_col_d        = nbr.col;
            top_dir_d        = DIR_DOWN;
          end
        end
      end

      ST_EMIT: begin
        emit_row_d = emit_row_q + RC_W'(1);
        if (emit_row_q == RC_W'(SIDE - 1)) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      marks_q    <= '0;
      sp_q       <= '0;
      found_q    <= 1'b0;
      emit_row_q <= '0;
    end else begin
      state_q    <= state_d;
      marks_q    <= marks_d;
      sp_q       <= sp_d;
      found_q    <= found_d;
      emit_row_q <= emit_row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_row_q <= top_row_d;
    top_col_q <= top_col_d;
    top_dir_q <= top_dir_d;
    if (load_we) begin
      maze_q[load_pos] <= cell_open_i;
    end
    if (stk_we) begin
      stk_q[stk_waddr] <= stk_wdata;
    end
  end

  // Result beat: one grid row per cycle from the path marks
  always_comb begin
    row_path_bits_o = '0;
    for (int c = 0; c < 4; c++) begin
      if (c < SIDE) begin
        row_path_bits_o[c] = marks_q[POS_W'(int'(emit_row_q) * SIDE + c)];
      end
    end
  end

  assign busy_o       = (state_q != ST_IDLE);
  assign row_valid_o  = (state_q == ST_EMIT);
  assign row_index_o  = 2'(emit_row_q);
  assign path_found_o = found_q;
  assign last_row_o   = (emit_row_q == RC_W'(SIDE - 1));

endmodule

`default_nettype wire
